>>> rtl/lcfr_pkg.sv
// Shared types, codes and constants for the link command frame receiver.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package lcfr_pkg;

  // message buffer depth; a warning message ends after MESSAGE_BUFFER-1 bytes
  localparam int MESSAGE_BUFFER = 128;
  localparam int MSG_LIMIT      = MESSAGE_BUFFER - 1;
  // byte counter must also reach four for the matrix payload
  localparam int COUNT_W = ($clog2(MESSAGE_BUFFER) > 3) ? $clog2(MESSAGE_BUFFER) : 3;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int WORD_W   = 32;
  localparam int LEN_W    = 7;
  localparam int TICK_W   = 16;
  localparam int LEN_MAX  = 127;
  localparam int PAYLOAD_BYTES = 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;
  localparam logic [TICK_W-1:0]    TIMEOUT_RESET = 16'd200;

  // item operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // frame bytes
  localparam logic [BYTE_W-1:0] FRAME_START = 8'h8a;
  localparam logic [BYTE_W-1:0] CMD_REQ     = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_RESP    = 8'h81;
  localparam logic [BYTE_W-1:0] CMD_WARN    = 8'h82;
  localparam logic [BYTE_W-1:0] BYTE_NUL    = 8'h00;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_START  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CMD     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WRONG_ROLE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SHORT      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd5;

  // frame phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_CMD     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_MSG     = 2'd3;

  typedef struct packed {
    logic              role_is_master;
    logic [TICK_W-1:0] byte_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   command_code;
    logic [WORD_W-1:0]   matrix_word;
    logic [LEN_W-1:0]    message_length;
  } result_t;

  // message length as reported, saturated to the field width
  function automatic logic [LEN_W-1:0] sat_len(input logic [COUNT_W-1:0] count);
    if (count > COUNT_W'(LEN_MAX)) begin
      return LEN_W'(LEN_MAX);
    end
    return LEN_W'(count);
  endfunction

endpackage

`default_nettype wire

>>> rtl/lcfr_item_if.sv
// Input channel: a received byte or a microsecond tick, with valid/ready.
// Depends on lcfr_pkg for field widths.
`default_nettype none

interface lcfr_item_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [lcfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/lcfr_result_if.sv
// Result channel: one frame status request with valid/ready.
// Depends on lcfr_pkg for field widths.
`default_nettype none

interface lcfr_result_if;
  logic                          valid;
  logic                          ready;
  logic [lcfr_pkg::STATUS_W-1:0] status;
  logic [lcfr_pkg::BYTE_W-1:0]   command_code;
  logic [lcfr_pkg::WORD_W-1:0]   matrix_word;
  logic [lcfr_pkg::LEN_W-1:0]    message_length;

  modport source (output valid, output status, output command_code, output matrix_word,
                  output message_length, input ready);
  modport sink (input valid, input status, input command_code, input matrix_word,
                input message_length, output ready);
endinterface

`default_nettype wire

>>> rtl/lcfr_cfg_if.sv
// Configuration write channel: register index and write data with valid/ready.
// Depends on lcfr_pkg for widths.
`default_nettype none

interface lcfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lcfr_pkg::CFG_IDX_W-1:0] index;
  logic [lcfr_pkg::TICK_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/lcfr_cfg_regs.sv
// Configuration registers: master/slave role and inter-byte timeout.
// Depends on lcfr_pkg and lcfr_cfg_if.
`default_nettype none

module lcfr_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  lcfr_cfg_if.sink         cfg,
  output lcfr_pkg::cfg_t   settings
);

  lcfr_pkg::cfg_t regs;

  // writes are always taken
  assign cfg.ready = 1'b1;
  assign settings  = regs;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.role_is_master     <= 1'b0;
      regs.byte_timeout_ticks <= lcfr_pkg::TIMEOUT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        lcfr_pkg::CFG_ROLE:    regs.role_is_master     <= cfg.data[0];
        lcfr_pkg::CFG_TIMEOUT: regs.byte_timeout_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/lcfr_parser.sv
// Frame parser: phase, byte counter, payload word and gap counter, plus the
// one-step next-state logic. Depends on lcfr_pkg.
`default_nettype none

module lcfr_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic                        operation,
  input  wire logic [lcfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire lcfr_pkg::cfg_t              settings,
  output logic                             emit,
  output lcfr_pkg::result_t                res
);

  logic [1:0]                        phase, phase_next;
  logic [lcfr_pkg::COUNT_W-1:0]      byte_count, byte_count_next;
  logic [lcfr_pkg::WORD_W-1:0]       matrix_shift, matrix_shift_next;
  logic [lcfr_pkg::TICK_W-1:0]       gap_counter, gap_counter_next;
  logic [lcfr_pkg::BYTE_W-1:0]       current_command, current_command_next;

  logic [lcfr_pkg::COUNT_W-1:0]      count_inc;
  logic [lcfr_pkg::WORD_W-1:0]       merged;
  logic [4:0]                        shamt;

  assign count_inc = byte_count + lcfr_pkg::COUNT_W'(1);
  assign shamt     = {byte_count[1:0], 3'b000};
  assign merged    = matrix_shift | ({{(lcfr_pkg::WORD_W-lcfr_pkg::BYTE_W){1'b0}}, rx_byte}
                                     << shamt);

  // next state and result for one item
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    matrix_shift_next    = matrix_shift;
    gap_counter_next     = gap_counter;
    current_command_next = current_command;
    emit                 = 1'b0;
    res                  = '0;

    if (operation == lcfr_pkg::OP_TICK) begin
      // ticks only matter inside a frame
      if (phase != lcfr_pkg::PH_IDLE) begin
        if (gap_counter != settings.byte_timeout_ticks) begin
          gap_counter_next = gap_counter + lcfr_pkg::TICK_W'(1);
        end else begin
          emit = 1'b1;
          case (phase)
            lcfr_pkg::PH_CMD: begin
              res.status = lcfr_pkg::ST_NO_CMD;
            end
            lcfr_pkg::PH_PAYLOAD: begin
              res.status       = lcfr_pkg::ST_SHORT;
              res.command_code = current_command;
            end
            default: begin
              res.status         = lcfr_pkg::ST_OK;
              res.command_code   = current_command;
              res.message_length = lcfr_pkg::sat_len(byte_count);
            end
          endcase
        end
      end
    end else begin
      gap_counter_next = '0;
      case (phase)
        lcfr_pkg::PH_IDLE: begin
          if (rx_byte != lcfr_pkg::FRAME_START) begin
            emit       = 1'b1;
            res.status = lcfr_pkg::ST_BAD_START;
          end else begin
            phase_next = lcfr_pkg::PH_CMD;
          end
        end
        lcfr_pkg::PH_CMD: begin
          current_command_next = rx_byte;
          res.command_code     = rx_byte;
          if (rx_byte == lcfr_pkg::CMD_REQ) begin
            emit       = 1'b1;
            res.status = settings.role_is_master ? lcfr_pkg::ST_WRONG_ROLE : lcfr_pkg::ST_OK;
          end else if (rx_byte == lcfr_pkg::CMD_RESP || rx_byte == lcfr_pkg::CMD_WARN) begin
            if (!settings.role_is_master) begin
              emit       = 1'b1;
              res.status = lcfr_pkg::ST_WRONG_ROLE;
            end else begin
              byte_count_next   = '0;
              matrix_shift_next = '0;
              phase_next = (rx_byte == lcfr_pkg::CMD_RESP) ? lcfr_pkg::PH_PAYLOAD
                                                           : lcfr_pkg::PH_MSG;
            end
          end else begin
            emit       = 1'b1;
            res.status = lcfr_pkg::ST_UNKNOWN;
          end
        end
        lcfr_pkg::PH_PAYLOAD: begin
          // little-endian assembly of the key matrix word
          matrix_shift_next = merged;
          byte_count_next   = count_inc;
          if (count_inc >= lcfr_pkg::COUNT_W'(lcfr_pkg::PAYLOAD_BYTES)) begin
            emit             = 1'b1;
            res.status       = lcfr_pkg::ST_OK;
            res.command_code = current_command;
            res.matrix_word  = merged;
          end
        end
        default: begin
          // warning message: NUL terminates and is not counted
          res.status       = lcfr_pkg::ST_OK;
          res.command_code = current_command;
          if (rx_byte == lcfr_pkg::BYTE_NUL) begin
            emit               = 1'b1;
            res.message_length = lcfr_pkg::sat_len(byte_count);
          end else begin
            byte_count_next = count_inc;
            if (count_inc >= lcfr_pkg::COUNT_W'(lcfr_pkg::MSG_LIMIT)) begin
              emit               = 1'b1;
              res.message_length = lcfr_pkg::sat_len(count_inc);
            end
          end
        end
      endcase
    end

    // every finished frame returns to idle with a clear gap counter
    if (emit) begin
      phase_next       = lcfr_pkg::PH_IDLE;
      gap_counter_next = '0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lcfr_pkg::PH_IDLE;
      byte_count      <= '0;
      matrix_shift    <= '0;
      gap_counter     <= '0;
      current_command <= '0;
    end else if (step) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      matrix_shift    <= matrix_shift_next;
      gap_counter     <= gap_counter_next;
      current_command <= current_command_next;
    end
  end

  // checks
  a_idle_gap_clear: assert property (@(posedge clk) disable iff (rst)
    phase == lcfr_pkg::PH_IDLE |-> gap_counter == '0)
    else $error("gap counter running outside a frame");

  a_emit_ends_frame: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> phase == lcfr_pkg::PH_IDLE)
    else $error("frame still open after its status");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == lcfr_pkg::PH_PAYLOAD |-> byte_count < lcfr_pkg::COUNT_W'(lcfr_pkg::PAYLOAD_BYTES))
    else $error("matrix payload overran four bytes");

  a_msg_count: assert property (@(posedge clk) disable iff (rst)
    phase == lcfr_pkg::PH_MSG |-> byte_count < lcfr_pkg::COUNT_W'(lcfr_pkg::MSG_LIMIT))
    else $error("warning message overran the buffer");

endmodule

`default_nettype wire

>>> rtl/link_command_frame_receiver.sv
// Top level of the link command frame receiver: input register, parser, result register.
// Depends on lcfr_pkg, the three channel interfaces, lcfr_cfg_regs and lcfr_parser.
`default_nettype none

// Takes one item per clock: a received link byte (operation 0) or a microsecond
// tick (operation 1). Each item is captured in an input register and then handled
// by the parser; the status request of the item that ends its frame is held in the
// result register and shown on report. At most one request per item; mid-frame
// bytes, and ticks before the inter-byte timeout, give none. While a finished
// request waits on report, one more item can still be taken into the input
// register; the input side stalls only when both the input register and the result
// register are full and report is not ready. Frames: 0x8a, command, then four payload
// bytes for a matrix response or message bytes up to NUL / 127 bytes for a warning.
// Write role_is_master (index 0) and byte_timeout_ticks (index 1) while idle.
module link_command_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst,
  lcfr_cfg_if.sink        cfg,
  lcfr_item_if.sink       item,
  lcfr_result_if.source   report
);

  lcfr_pkg::cfg_t               settings;
  logic                         hold_valid;
  logic                         hold_op;
  logic [lcfr_pkg::BYTE_W-1:0]  hold_byte;
  logic                         out_valid;
  lcfr_pkg::result_t            out_res;
  lcfr_pkg::result_t            res;
  logic                         emit;
  logic                         advance;
  logic                         take;

  lcfr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  lcfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .operation (hold_op),
    .rx_byte   (hold_byte),
    .settings  (settings),
    .emit      (emit),
    .res       (res)
  );

  // handshake control
  assign advance    = hold_valid && (!out_valid || report.ready);
  assign item.ready = !hold_valid || advance;
  assign take       = item.valid && item.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_op   <= item.operation;
      hold_byte <= item.rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res <= res;
    end
  end

  assign report.valid          = out_valid;
  assign report.status         = out_res.status;
  assign report.command_code   = out_res.command_code;
  assign report.matrix_word    = out_res.matrix_word;
  assign report.message_length = out_res.message_length;

endmodule

`default_nettype wire
